FILE: rtl/core/red_pkg.sv
// Package: widths and constants for the rounded Euclidean distance core.
package red_pkg;

  localparam int COORD_BITS = 16;                  // coordinate width, two's complement
  localparam int DIST_BITS  = COORD_BITS + 1;      // rounded distance width
  localparam int ABS_BITS   = COORD_BITS;          // |a - b| fits the coordinate width
  localparam int SQ_BITS    = 2 * ABS_BITS;        // one squared difference
  localparam int SUM_BITS   = SQ_BITS + 1;         // sum of the two squares
  localparam int RAD_BITS   = 2 * DIST_BITS;       // radicand, padded to whole digit pairs
  localparam int REM_BITS   = DIST_BITS + 1;       // root remainder, at most 2 * root
  localparam int SQRT_STEPS = DIST_BITS;           // one root bit per pipeline stage

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [DIST_BITS-1:0]  dist_t;

endpackage

FILE: rtl/core/rounded_euclidean_distance_core.sv
// Top level: pipelined rounded Euclidean distance between two integer points.
//
//  channel | ports                              | dir | handshake
//  --------+------------------------------------+-----+-----------------------
//  input   | in_ax, in_ay, in_bx, in_by         | in  | in_valid / in_ready
//  result  | out_distance                       | out | out_valid / out_ready
//
// One item enters per cycle while the output is not stalled; the square root resolves
// one root bit per stage.
// Stages: abs differences, squares, sum, DIST_BITS root digit stages, rounding.
// The whole pipeline advances together whenever the output register is empty or
// its transfer completes, so a stall freezes every stage and nothing is lost.
// Reset (rst_n, synchronous, active low) clears the valid bits only.
module rounded_euclidean_distance_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  red_pkg::coord_t       in_ax,
  input  red_pkg::coord_t       in_ay,
  input  red_pkg::coord_t       in_bx,
  input  red_pkg::coord_t       in_by,
  output logic                  out_valid,
  input  logic                  out_ready,
  output red_pkg::dist_t        out_distance
);
  import red_pkg::*;

  // Global advance: the output register is free or is being drained now.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 1: sign-extended differences and their magnitudes.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS:0] dx_s, dy_s;
  logic        [COORD_BITS:0] dx_neg, dy_neg;
  logic        [ABS_BITS-1:0] dx_nxt, dy_nxt;
  logic        [ABS_BITS-1:0] dx_r, dy_r;
  logic                       v1_r;

  always_comb begin
    dx_s   = {in_ax[COORD_BITS-1], in_ax} - {in_bx[COORD_BITS-1], in_bx};
    dy_s   = {in_ay[COORD_BITS-1], in_ay} - {in_by[COORD_BITS-1], in_by};
    dx_neg = -dx_s;
    dy_neg = -dy_s;
    // The magnitude never exceeds 2^COORD_BITS - 1, so drop the top bit.
    dx_nxt = dx_s[COORD_BITS] ? dx_neg[ABS_BITS-1:0] : dx_s[ABS_BITS-1:0];
    dy_nxt = dy_s[COORD_BITS] ? dy_neg[ABS_BITS-1:0] : dy_s[ABS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: one multiplier per axis.
  // ---------------------------------------------------------------------------
  logic [SQ_BITS-1:0] sqx_r, sqy_r;
  logic               v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= dx_r * dx_r;
      sqy_r <= dy_r * dy_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum of squares, loaded as the radicand of root stage 0.
  // Root stages k = 0..SQRT_STEPS: rad holds the digit pairs still to consume
  // (top aligned), rem the partial remainder, root the bits found so far.
  // ---------------------------------------------------------------------------
  logic [RAD_BITS-1:0] rad_r  [0:SQRT_STEPS];
  logic [REM_BITS-1:0] rem_r  [0:SQRT_STEPS];
  logic [DIST_BITS-1:0] root_r [0:SQRT_STEPS];
  logic                 vs_r   [0:SQRT_STEPS];
  logic [SUM_BITS-1:0]  sum_nxt;

  assign sum_nxt = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (adv) begin
      vs_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r[0]  <= {{(RAD_BITS-SUM_BITS){1'b0}}, sum_nxt};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // One restoring digit step per stage: bring down two radicand bits, try
  // subtracting 4*root + 1, keep the difference and set the root bit if it fits.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
    logic [REM_BITS+1:0]  rem_sh;
    logic [REM_BITS+1:0]  trial;
    logic [REM_BITS+1:0]  diff;
    logic                 fits;
    logic [REM_BITS-1:0]  rem_nxt;
    logic [DIST_BITS-1:0] root_nxt;

    always_comb begin
      rem_sh   = {rem_r[k], rad_r[k][RAD_BITS-1 -: 2]};
      trial    = {{(REM_BITS-DIST_BITS){1'b0}}, root_r[k], 2'b01};
      diff     = rem_sh - trial;
      fits     = (rem_sh >= trial);
      rem_nxt  = fits ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
      root_nxt = {root_r[k][DIST_BITS-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k+1] <= 1'b0;
      end else if (adv) begin
        vs_r[k+1] <= vs_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k+1]  <= {rad_r[k][RAD_BITS-3:0], 2'b00};
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage: round to nearest. rem = s - r*r, so s > r*r + r is rem > r.
  // The output register doubles as the skid between the pipe and the consumer.
  // ---------------------------------------------------------------------------
  logic                 out_valid_r;
  logic [DIST_BITS-1:0] out_distance_r;
  logic                 round_up;

  assign round_up = (rem_r[SQRT_STEPS] > {1'b0, root_r[SQRT_STEPS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs_r[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_distance_r <= root_r[SQRT_STEPS] + {{(DIST_BITS-1){1'b0}}, round_up};
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The finished remainder never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r[SQRT_STEPS] |-> (rem_r[SQRT_STEPS] <= {root_r[SQRT_STEPS], 1'b0}))
    else $error("root remainder out of range");

  // A stall freezes the last root stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(root_r[SQRT_STEPS]) && $stable(rem_r[SQRT_STEPS])
             && $stable(vs_r[SQRT_STEPS]))
    else $error("root pipeline moved during a stall");

  // A result disappears only through a completed transfer.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped without a transfer");

endmodule
